// ===== hdl/sphd_pkg.sv =====
package sphd_pkg;

	localparam int PAT_MAX_DEF = 32;
	localparam int SYMBOL_BITS_DEF = 8;

	localparam int OP_W = 2;
	localparam int SLOT_W = 5;
	localparam int SYM_W = 8;
	localparam int POS_W = 16;
	localparam int DIST_W = 6;
	localparam int LEN_W = 6;
	localparam int ALPHA_W = 9;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
	localparam logic [OP_W-1:0] OP_TEXT = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam logic REG_PATTERN_LENGTH = 1'b0;
	localparam logic REG_ALPHABET_SIZE = 1'b1;

	localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = 6'd32;
	localparam logic [ALPHA_W-1:0] ALPHABET_SIZE_RST = 9'd256;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [SLOT_W-1:0] slot;
		logic [SYM_W-1:0] symbol;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] window_start;
		logic [DIST_W-1:0] distance;
	} result_t;

	typedef struct packed {
		logic adv;
		logic [ALPHA_W-1:0] alpha;
	} cell_ctrl_t;

endpackage

// ===== hdl/sliding_pattern_hamming_distance.sv =====
// Streams text symbols past a stored pattern and reports, for every full window, its start
// position and Hamming distance to the pattern. The item channel accepts one word per cycle
// unless a held result stalls it, and a result appears on the result channel in the cycle
// after its text word is accepted. The row of PAT_MAX compare cells carries partial mismatch
// counts one cell per word, so after a pattern write or an alphabet_size write the next text
// word waits while the row replays the held text window, then proceeds at one per cycle.
module sliding_pattern_hamming_distance #(
	parameter int PAT_MAX = sphd_pkg::PAT_MAX_DEF,
	parameter int SYMBOL_BITS = sphd_pkg::SYMBOL_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input sphd_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output sphd_pkg::result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [sphd_pkg::ADDR_W-1:0] paddr,
	input logic [sphd_pkg::DATA_W-1:0] pwdata,
	output logic [sphd_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	localparam int AW = $clog2(PAT_MAX + 1);
	localparam int IW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
	localparam logic [IW-1:0] RB_LAST = IW'(PAT_MAX - 1);

	typedef enum logic [1:0] {
		ST_RUN = 2'b01,
		ST_REBUILD = 2'b10
	} state_t;

	state_t st_q;
	logic [IW-1:0] rb_cnt_q;
	logic dirty_q;
	logic [sphd_pkg::LEN_W-1:0] pattern_length_q;
	logic [sphd_pkg::ALPHA_W-1:0] alphabet_size_q;
	logic [AW-1:0] fill_q;
	logic [sphd_pkg::POS_W-1:0] pos_q;
	logic result_valid_q;
	sphd_pkg::result_t result_q;

	logic cfg_wr;
	logic accept;
	logic is_text;
	logic rebuilding;
	logic start_rebuild;
	logic [15:0] sym_wide;
	logic [SYMBOL_BITS-1:0] sym;
	logic [SYMBOL_BITS-1:0] feed;
	logic [AW-1:0] m_eff;
	logic [IW-1:0] m_idx;
	logic [AW-1:0] fill_new;
	logic [sphd_pkg::POS_W-1:0] pos_new;
	logic produce;
	sphd_pkg::cell_ctrl_t ctrl;

	logic [SYMBOL_BITS-1:0] text_out [PAT_MAX];
	logic [AW-1:0] acc_out [PAT_MAX];
	logic [AW-1:0] acc_next [PAT_MAX];
	logic [PAT_MAX-1:0] pat_we;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			sphd_pkg::REG_PATTERN_LENGTH: prdata = sphd_pkg::DATA_W'(pattern_length_q);
			sphd_pkg::REG_ALPHABET_SIZE: prdata = sphd_pkg::DATA_W'(alphabet_size_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= sphd_pkg::PATTERN_LENGTH_RST;
			alphabet_size_q <= sphd_pkg::ALPHABET_SIZE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				sphd_pkg::REG_PATTERN_LENGTH: begin
					pattern_length_q <= pwdata[sphd_pkg::LEN_W-1:0];
				end
				sphd_pkg::REG_ALPHABET_SIZE: begin
					alphabet_size_q <= pwdata[sphd_pkg::ALPHA_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign sym_wide = 16'(item.symbol);
	assign sym = sym_wide[SYMBOL_BITS-1:0];
	assign is_text = item.operation == sphd_pkg::OP_TEXT;
	assign rebuilding = st_q == ST_REBUILD;
	assign start_rebuild = (st_q == ST_RUN) && dirty_q && item_valid && is_text;
	assign item_ready = (st_q == ST_RUN) && !(dirty_q && is_text) &&
		(!result_valid_q || result_ready);
	assign accept = item_valid && item_ready;

	always_comb begin
		if (pattern_length_q == '0) begin
			m_eff = AW'(1);
		end else if (32'(pattern_length_q) > 32'(PAT_MAX)) begin
			m_eff = AW'(PAT_MAX);
		end else begin
			m_eff = AW'(pattern_length_q);
		end
	end

	assign m_idx = IW'(m_eff - AW'(1));
	assign fill_new = (fill_q < AW'(PAT_MAX)) ? fill_q + AW'(1) : fill_q;
	assign pos_new = pos_q + sphd_pkg::POS_W'(1);
	assign produce = fill_new >= m_eff;

	assign feed = rebuilding ? text_out[PAT_MAX-1] : sym;
	assign ctrl.adv = rebuilding || (accept && is_text);
	assign ctrl.alpha = alphabet_size_q;

	for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
		logic [SYMBOL_BITS-1:0] text_in;
		logic [AW-1:0] acc_in;

		assign pat_we[k] = accept && (item.operation == sphd_pkg::OP_PATTERN) &&
			(32'(item.slot) == k);

		if (k == 0) begin : g_head
			assign text_in = feed;
			assign acc_in = '0;
		end else begin : g_body
			assign text_in = text_out[k-1];
			assign acc_in = acc_out[k-1];
		end

		sphd_cell #(
			.SYMBOL_BITS(SYMBOL_BITS),
			.ACC_W(AW)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.pat_we(pat_we[k]),
			.feed(feed),
			.text_in(text_in),
			.acc_in(acc_in),
			.text_out(text_out[k]),
			.acc_out(acc_out[k]),
			.acc_next(acc_next[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
			rb_cnt_q <= '0;
			dirty_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_RUN: begin
					if (start_rebuild) begin
						st_q <= ST_REBUILD;
						rb_cnt_q <= '0;
					end
				end
				ST_REBUILD: begin
					rb_cnt_q <= rb_cnt_q + IW'(1);
					if (rb_cnt_q == RB_LAST) begin
						st_q <= ST_RUN;
					end
				end
				default: begin
					st_q <= ST_RUN;
				end
			endcase
			if (rebuilding && (rb_cnt_q == RB_LAST)) begin
				dirty_q <= 1'b0;
			end else if (accept && (item.operation == sphd_pkg::OP_RESTART)) begin
				dirty_q <= 1'b0;
			end else if (accept && (item.operation == sphd_pkg::OP_PATTERN)) begin
				dirty_q <= 1'b1;
			end else if (cfg_wr && (paddr[2] == sphd_pkg::REG_ALPHABET_SIZE)) begin
				dirty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q <= '0;
		end else if (accept && (item.operation == sphd_pkg::OP_RESTART)) begin
			fill_q <= '0;
			pos_q <= '0;
		end else if (accept && is_text) begin
			fill_q <= fill_new;
			pos_q <= pos_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept && is_text && produce) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_text && produce) begin
			result_q.window_start <= pos_new - sphd_pkg::POS_W'(m_eff);
			result_q.distance <= sphd_pkg::DIST_W'(acc_next[m_idx]);
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef SYNTH
	a_result_from_text: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready &&
		(item.operation == sphd_pkg::OP_TEXT)))
		else $error("result raised without an accepted text word");

	a_no_accept_in_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_REBUILD) |-> !item_ready)
		else $error("word accepted while the cell row is replaying");

	a_rebuild_ends_clean: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_REBUILD) && (rb_cnt_q == RB_LAST)) |=> (!dirty_q && (st_q == ST_RUN)))
		else $error("replay finished without clearing the stale flag");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(PAT_MAX))
		else $error("fill count above the row length");
`endif

endmodule

// ===== hdl/sphd_cell.sv =====
module sphd_cell #(
	parameter int SYMBOL_BITS = sphd_pkg::SYMBOL_BITS_DEF,
	parameter int ACC_W = 6
) (
	input logic clk,
	input sphd_pkg::cell_ctrl_t ctrl,
	input logic pat_we,
	input logic [SYMBOL_BITS-1:0] feed,
	input logic [SYMBOL_BITS-1:0] text_in,
	input logic [ACC_W-1:0] acc_in,
	output logic [SYMBOL_BITS-1:0] text_out,
	output logic [ACC_W-1:0] acc_out,
	output logic [ACC_W-1:0] acc_next
);

	localparam int CMP_W = ((SYMBOL_BITS > sphd_pkg::ALPHA_W) ? SYMBOL_BITS :
		sphd_pkg::ALPHA_W) + 1;

	logic [SYMBOL_BITS-1:0] pat_q;
	logic [SYMBOL_BITS-1:0] text_q;
	logic [ACC_W-1:0] acc_q;
	logic counted;
	logic mismatch;

	assign counted = CMP_W'(feed) < CMP_W'(ctrl.alpha);
	assign mismatch = counted && (feed != pat_q);
	assign acc_next = acc_in + ACC_W'(mismatch);

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_q <= feed;
		end
		if (ctrl.adv) begin
			text_q <= text_in;
			acc_q <= acc_next;
		end
	end

	assign text_out = text_q;
	assign acc_out = acc_q;

endmodule
